// ===== src/rfir_pkg.sv =====
// Shared types and constants for the replicate-border row FIR filter.
`timescale 1ns / 1ps

package rfir_pkg;

  localparam int MAX_HALF_WIDTH = 3;
  localparam int SAMPLE_BITS    = 16;
  localparam int WEIGHT_BITS    = 16;
  localparam int FRAC_BITS      = 14;
  localparam int WIN_DEPTH      = 2 * MAX_HALF_WIDTH;
  localparam int NUM_TAPS       = 2 * MAX_HALF_WIDTH + 1;
  localparam int HW_BITS        = 2;
  localparam int TAP_IDX_BITS   = $clog2(NUM_TAPS);
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int PROD_BITS      = SAMPLE_BITS + WEIGHT_BITS;
  localparam int ACC_BITS       = PROD_BITS + $clog2(NUM_TAPS);

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_WIDTH = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WEIGHT_0   = 3'd1;

  localparam logic signed [WEIGHT_BITS-1:0] WEIGHT_0_RESET = 16'sd16384;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          row_end;
  } rfir_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          row_done;
    logic                          clipped;
  } rfir_out_t;

endpackage

// ===== src/row_fir_replicate_border.sv =====
// Top level of the streaming row FIR filter with replicated borders.
`timescale 1ns / 1ps

// Streaming odd-length FIR over one image row, 2h+1 taps (h from 0 to 3),
// Q2.14 weights, rounded and saturated 16-bit results with a clip flag.
// Results trail the input by h samples; a row-end request releases the
// pending h+1 results (fewer for a row shorter than h+1), the last one
// marked with row_done. One request is taken per clock cycle unless the
// output stalls; a row-end request occupies the tap stage until its last
// result has entered the output register, holding off the next request.
// The tap stage feeds seven parallel multipliers and an adder tree into the output
// register, which lets a new request enter while a result waits to be taken.
// Configuration may be written only while no request is in flight.
module row_fir_replicate_border import rfir_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  rfir_in_t                 in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output rfir_out_t                out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) <<< (FRAC_BITS - 1);
  localparam int RES_BITS = ACC_BITS - FRAC_BITS;
  localparam logic signed [RES_BITS-1:0] SAT_HI =
    RES_BITS'((longint'(1) <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [RES_BITS-1:0] SAT_LO = ~SAT_HI;

  // Configuration
  logic [HW_BITS-1:0]                 half_width_q;
  logic signed [WEIGHT_BITS-1:0]      weight_q [NUM_TAPS];
  logic [CFG_IDX_BITS-1:0]            weight_idx;

  // Row state
  logic signed [SAMPLE_BITS-1:0]      window_q [WIN_DEPTH];
  logic [HW_BITS-1:0]                 row_pos_q;

  // Tap stage
  logic                               tap_valid_q;
  logic signed [SAMPLE_BITS-1:0]      taps_q [NUM_TAPS];
  logic signed [SAMPLE_BITS-1:0]      taps_d [NUM_TAPS];
  logic signed [SAMPLE_BITS-1:0]      edge_q;
  logic [HW_BITS-1:0]                 tap_hw_q;
  logic [HW_BITS-1:0]                 remain_q;
  logic [HW_BITS-1:0]                 remain_d;
  logic                               tap_end_q;

  // Output stage
  logic                               out_valid_q;
  rfir_out_t                          out_q;
  rfir_out_t                          out_d;

  logic                               in_fire;
  logic                               advance;
  logic                               last_step;
  logic                               emits;
  logic signed [SAMPLE_BITS-1:0]      x;
  logic signed [SAMPLE_BITS-1:0]      win_eff [WIN_DEPTH];
  logic signed [PROD_BITS-1:0]        prod [NUM_TAPS];
  logic signed [ACC_BITS-1:0]         acc;
  logic signed [ACC_BITS-1:0]         rounded;
  logic signed [RES_BITS-1:0]         res;
  logic [TAP_IDX_BITS:0]              two_h;
  logic [HW_BITS-1:0]                 first;

  assign cfg_ready_o = 1'b1;
  assign weight_idx  = cfg_index_i - CFG_WEIGHT_0;

  assign advance     = tap_valid_q && (!out_valid_q || out_ready_i);
  assign last_step   = remain_q == '0;
  assign in_ready_o  = !tap_valid_q || (advance && last_step);
  assign in_fire     = in_valid_i && in_ready_o;
  assign x           = in_data_i.sample_in;
  assign emits       = in_data_i.row_end || (row_pos_q >= half_width_q);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Left border: a row start fills the whole window with its first sample
  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win_eff[i] = (row_pos_q == '0) ? x : window_q[i];
    end
  end

  // Load the taps for the first result this request releases
  always_comb begin
    logic [TAP_IDX_BITS:0] idx;
    logic [TAP_IDX_BITS:0] widx;
    two_h = {1'b0, half_width_q, 1'b0};
    first = '0;
    remain_d = '0;
    if (in_data_i.row_end) begin
      if (row_pos_q >= half_width_q) begin
        remain_d = half_width_q;
      end else begin
        first    = half_width_q - row_pos_q;
        remain_d = row_pos_q;
      end
    end
    for (int k = 0; k < NUM_TAPS; k++) begin
      idx  = (TAP_IDX_BITS + 1)'(first) + (TAP_IDX_BITS + 1)'(k);
      widx = (TAP_IDX_BITS + 1)'(WIN_DEPTH) - two_h + idx;
      if (idx < two_h) begin
        taps_d[k] = win_eff[widx[TAP_IDX_BITS-1:0]];
      end else begin
        taps_d[k] = x;
      end
    end
  end

  // Weighted sum, round half up, drop fraction, saturate
  always_comb begin
    logic [TAP_IDX_BITS:0] tap_two_h;
    tap_two_h = {1'b0, tap_hw_q, 1'b0};
    acc = '0;
    for (int k = 0; k < NUM_TAPS; k++) begin
      prod[k] = taps_q[k] * weight_q[k];
      if ((TAP_IDX_BITS + 1)'(k) <= tap_two_h) begin
        acc = acc + ACC_BITS'(prod[k]);
      end
    end
    rounded = acc + ROUND_HALF;
    res     = rounded[ACC_BITS-1:FRAC_BITS];
    out_d.row_done = tap_end_q && last_step;
    if (res > SAT_HI) begin
      out_d.filtered = SAT_HI[SAMPLE_BITS-1:0];
      out_d.clipped  = 1'b1;
    end else if (res < SAT_LO) begin
      out_d.filtered = SAT_LO[SAMPLE_BITS-1:0];
      out_d.clipped  = 1'b1;
    end else begin
      out_d.filtered = res[SAMPLE_BITS-1:0];
      out_d.clipped  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q <= '0;
      for (int k = 0; k < NUM_TAPS; k++) begin
        weight_q[k] <= (k == 0) ? WEIGHT_0_RESET : '0;
      end
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_HALF_WIDTH) begin
        half_width_q <= cfg_data_i[HW_BITS-1:0];
      end else begin
        weight_q[weight_idx] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_pos_q <= '0;
      for (int i = 0; i < WIN_DEPTH; i++) begin
        window_q[i] <= '0;
      end
    end else if (in_fire) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        window_q[i] <= win_eff[i+1];
      end
      window_q[WIN_DEPTH-1] <= x;
      if (in_data_i.row_end) begin
        row_pos_q <= '0;
      end else if (row_pos_q != HW_BITS'(MAX_HALF_WIDTH)) begin
        row_pos_q <= row_pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_valid_q <= 1'b0;
    end else if (in_fire) begin
      tap_valid_q <= emits;
    end else if (advance && last_step) begin
      tap_valid_q <= 1'b0;
    end
  end

  // Tap payload: load on a new request, shift the right border in per result
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      taps_q    <= taps_d;
      edge_q    <= x;
      tap_hw_q  <= half_width_q;
      remain_q  <= remain_d;
      tap_end_q <= in_data_i.row_end;
    end else if (advance) begin
      for (int k = 0; k < NUM_TAPS - 1; k++) begin
        taps_q[k] <= taps_q[k+1];
      end
      taps_q[NUM_TAPS-1] <= edge_q;
      remain_q <= remain_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

endmodule
